[hdl/sbpf_pkg.sv]
// Package with the constants, the sequencer state type and the CRC-16 byte update.
`default_nettype none
package sbpf_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 240;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  HDR3_BYTE      = 8'hFD;
    localparam logic [7:0]  RSV_BYTE       = 8'h00;
    localparam logic [7:0]  INSTR_WRITE    = 8'h03;
    localparam logic [7:0]  INSTR_SYNC_WR  = 8'h83;
    localparam logic [7:0]  BROADCAST_ID   = 8'hFE;
    localparam logic [15:0] CRC_POLY       = 16'h8005;
    localparam logic [15:0] LEN_EXTRA_WR   = 16'd5;
    localparam logic [15:0] LEN_EXTRA_SYNC = 16'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FF1,
        S_FF2,
        S_FD,
        S_RSV,
        S_ID,
        S_LENL,
        S_LENH,
        S_INSTR,
        S_ADDRL,
        S_ADDRH,
        S_DLENL,
        S_DLENH,
        S_DATA,
        S_CRCL,
        S_CRCH
    } t_state;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/sbpf_if.sv]
// Handshake interfaces for the payload-byte input channel and the framed-byte output channel.
`default_nettype none
interface sbpf_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  device_id;
    logic [15:0] start_address;
    logic [15:0] bytes_per_device;
    logic [7:0]  payload_count;
    logic [7:0]  data_byte;

    modport source (
        output valid, cmd, device_id, start_address, bytes_per_device,
               payload_count, data_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, device_id, start_address, bytes_per_device,
               payload_count, data_byte,
        output ready
    );
endinterface

interface sbpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_packet;

    modport source (
        output valid, out_byte, end_of_packet,
        input  ready
    );
    modport sink (
        input  valid, out_byte, end_of_packet,
        output ready
    );
endinterface
`default_nettype wire

[hdl/sbpf_seq.sv]
// Byte sequencer that holds one input beat and emits its header, payload and CRC bytes.
`default_nettype none
module sbpf_seq
    import sbpf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sbpf_in_if.sink   i_in,
    sbpf_out_if.source o_out
);

    localparam logic [7:0] MaxCount = 8'(MAX_PAYLOAD);

    t_state      r_state, n_state;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_crc, n_crc;
    logic        r_is_sync, n_is_sync;

    logic        r_cmd;
    logic [7:0]  r_id;
    logic [15:0] r_addr;
    logic [15:0] r_dlen;
    logic [7:0]  r_count;
    logic [7:0]  r_data;

    logic        fire;
    logic        item_done;
    logic        in_fire;
    logic [7:0]  sat_count;
    logic [15:0] len;
    logic [7:0]  beat_byte;

    always_comb begin
        if (i_in.payload_count == 8'd0) begin
            sat_count = 8'd1;
        end else if (i_in.payload_count > MaxCount) begin
            sat_count = MaxCount;
        end else begin
            sat_count = i_in.payload_count;
        end
    end

    assign len = {8'h00, r_count} + (r_is_sync ? LEN_EXTRA_SYNC : LEN_EXTRA_WR);

    always_comb begin
        unique case (r_state)
            S_FF1, S_FF2: beat_byte = SYNC_BYTE;
            S_FD:         beat_byte = HDR3_BYTE;
            S_RSV:        beat_byte = RSV_BYTE;
            S_ID:         beat_byte = r_is_sync ? BROADCAST_ID : r_id;
            S_LENL:       beat_byte = len[7:0];
            S_LENH:       beat_byte = len[15:8];
            S_INSTR:      beat_byte = r_is_sync ? INSTR_SYNC_WR : INSTR_WRITE;
            S_ADDRL:      beat_byte = r_addr[7:0];
            S_ADDRH:      beat_byte = r_addr[15:8];
            S_DLENL:      beat_byte = r_dlen[7:0];
            S_DLENH:      beat_byte = r_dlen[15:8];
            S_DATA:       beat_byte = r_data;
            S_CRCL:       beat_byte = r_crc[7:0];
            S_CRCH:       beat_byte = r_crc[15:8];
            default:      beat_byte = 8'h00;
        endcase
    end

    always_comb begin
        item_done = 1'b0;
        if (r_state == S_DATA) begin
            item_done = (r_bytes_left != 8'd1);
        end else if (r_state == S_CRCH) begin
            item_done = 1'b1;
        end
    end

    assign o_out.valid         = (r_state != S_IDLE);
    assign o_out.out_byte      = beat_byte;
    assign o_out.end_of_packet = (r_state == S_CRCH);
    assign fire                = o_out.valid && o_out.ready;
    assign i_in.ready          = (r_state == S_IDLE) || (fire && item_done);
    assign in_fire             = i_in.valid && i_in.ready;

    always_comb begin
        n_state      = r_state;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_is_sync    = r_is_sync;
        if (fire) begin
            if (r_state == S_FF1) begin
                n_crc        = crc16_byte(16'h0000, beat_byte);
                n_is_sync    = r_cmd;
                n_bytes_left = r_count;
            end else if (r_state != S_CRCL && r_state != S_CRCH) begin
                n_crc = crc16_byte(r_crc, beat_byte);
            end
            unique case (r_state)
                S_FF1:   n_state = S_FF2;
                S_FF2:   n_state = S_FD;
                S_FD:    n_state = S_RSV;
                S_RSV:   n_state = S_ID;
                S_ID:    n_state = S_LENL;
                S_LENL:  n_state = S_LENH;
                S_LENH:  n_state = S_INSTR;
                S_INSTR: n_state = S_ADDRL;
                S_ADDRL: n_state = S_ADDRH;
                S_ADDRH: n_state = r_is_sync ? S_DLENL : S_DATA;
                S_DLENL: n_state = S_DLENH;
                S_DLENH: n_state = S_DATA;
                S_DATA: begin
                    n_bytes_left = r_bytes_left - 8'd1;
                    n_state      = (n_bytes_left == 8'd0) ? S_CRCL : S_IDLE;
                end
                S_CRCL:  n_state = S_CRCH;
                S_CRCH:  n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
        if (in_fire) begin
            n_state = (n_bytes_left == 8'd0) ? S_FF1 : S_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bytes_left <= 8'd0;
            r_crc        <= 16'h0000;
            r_is_sync    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_is_sync    <= n_is_sync;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_in.cmd;
            r_id    <= i_in.device_id;
            r_addr  <= i_in.start_address;
            r_dlen  <= i_in.bytes_per_device;
            r_count <= sat_count;
            r_data  <= i_in.data_byte;
        end
    end

endmodule
`default_nettype wire

[hdl/sbpf_obuf.sv]
// Registered output stage with a skid entry, so the ready toward the sequencer comes from a register.
`default_nettype none
module sbpf_obuf (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sbpf_out_if.sink   i_up,
    sbpf_out_if.source o_dn
);

    logic       r_out_v;
    logic [7:0] r_out_byte;
    logic       r_out_eop;
    logic       r_skid_v;
    logic [7:0] r_skid_byte;
    logic       r_skid_eop;
    logic       up_fire;
    logic       load;

    assign i_up.ready         = !r_skid_v;
    assign up_fire            = i_up.valid && !r_skid_v;
    assign load               = !r_out_v || o_dn.ready;
    assign o_dn.valid         = r_out_v;
    assign o_dn.out_byte      = r_out_byte;
    assign o_dn.end_of_packet = r_out_eop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load) begin
            r_out_v  <= r_skid_v || up_fire;
            r_skid_v <= 1'b0;
        end else if (up_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_skid_v) begin
                r_out_byte <= r_skid_byte;
                r_out_eop  <= r_skid_eop;
            end else begin
                r_out_byte <= i_up.out_byte;
                r_out_eop  <= i_up.end_of_packet;
            end
        end else if (up_fire) begin
            r_skid_byte <= i_up.out_byte;
            r_skid_eop  <= i_up.end_of_packet;
        end
    end

endmodule
`default_nettype wire

[hdl/servo_bus_packet_framer_crc16_unit.sv]
// Top level of the instruction packet framer with CRC-16.
// Each input beat carries one payload byte; the first beat of a packet also supplies the
// command, ID, address, data length and payload count, which are ignored on later beats.
// Output runs at one framed byte per cycle while the receiver is ready, which sets the rate:
// a continuing beat yields its payload byte, a first beat the header (data length only for
// a sync write) plus its payload byte, and the last beat adds the two CRC bytes. Bytes pass
// through the registered output stage, via its skid entry when stalled, and the next input
// beat is taken in the same cycle as the previous beat's last byte leaves the sequencer.
`default_nettype none
module servo_bus_packet_framer_crc16_unit
    import sbpf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sbpf_in_if.sink    i_in,
    sbpf_out_if.source o_out
);

    sbpf_out_if u_beat ();

    sbpf_seq #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .o_out  (u_beat)
    );

    sbpf_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_up   (u_beat),
        .o_dn   (o_out)
    );

endmodule
`default_nettype wire

[bench/servo_bus_packet_framer_crc16_unit_test.sv]
// Self-checking testbench for the instruction packet framer: random packets in, framed bytes checked.
`default_nettype none
module servo_bus_packet_framer_crc16_unit_test;
    import sbpf_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_framed_byte;

    class t_frame_tracker;
        t_framed_byte frame_bytes_due[$];
        logic [15:0]  running_crc;
        int unsigned  payload_remaining;
        int unsigned  mismatch_count;

        function new();
            running_crc       = '0;
            payload_remaining = 0;
            mismatch_count    = 0;
        endfunction

        static function logic [15:0] crc_advance(logic [15:0] crc, logic [7:0] b);
            logic feedback;
            for (int i = 7; i >= 0; i--) begin
                feedback = crc[15] ^ b[i];
                crc = {crc[14:0], 1'b0};
                if (feedback) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            return crc;
        endfunction

        function void emit(logic [7:0] value, logic last);
            t_framed_byte fb;
            fb.value = value;
            fb.last  = last;
            frame_bytes_due.push_back(fb);
            if (!last) begin
                running_crc = crc_advance(running_crc, value);
            end
        endfunction

        function void take_payload_beat(logic is_sync, logic [7:0] id, logic [15:0] addr,
                                        logic [15:0] dlen, logic [7:0] count,
                                        logic [7:0] data);
            int unsigned n;
            logic [15:0] total_len;
            logic [15:0] crc_out;
            if (payload_remaining == 0) begin
                n = (count == 0) ? 1 : count;
                if (n > MAX_PAYLOAD_DEF) begin
                    n = MAX_PAYLOAD_DEF;
                end
                running_crc = '0;
                total_len = 16'(n) + (is_sync ? LEN_EXTRA_SYNC : LEN_EXTRA_WR);
                emit(SYNC_BYTE, 1'b0);
                emit(SYNC_BYTE, 1'b0);
                emit(HDR3_BYTE, 1'b0);
                emit(RSV_BYTE, 1'b0);
                emit(is_sync ? BROADCAST_ID : id, 1'b0);
                emit(total_len[7:0], 1'b0);
                emit(total_len[15:8], 1'b0);
                emit(is_sync ? INSTR_SYNC_WR : INSTR_WRITE, 1'b0);
                emit(addr[7:0], 1'b0);
                emit(addr[15:8], 1'b0);
                if (is_sync) begin
                    emit(dlen[7:0], 1'b0);
                    emit(dlen[15:8], 1'b0);
                end
                payload_remaining = n;
            end
            emit(data, 1'b0);
            payload_remaining--;
            if (payload_remaining == 0) begin
                crc_out = running_crc;
                emit(crc_out[7:0], 1'b0);
                emit(crc_out[15:8], 1'b1);
            end
        endfunction

        function void check_framed_byte(logic [7:0] value, logic last);
            t_framed_byte due;
            if (frame_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected byte %02h eop %0b", $time, value, last);
                end
                return;
            end
            due = frame_bytes_due.pop_front();
            if (due.value !== value || due.last !== last) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: byte expected %02h got %02h, eop expected %0b got %0b",
                             $time, due.value, value, due.last, last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   gaps_on = 1'b0;
    t_frame_tracker ledger = new();

    sbpf_in_if  in_bus();
    sbpf_out_if out_bus();

    servo_bus_packet_framer_crc16_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                ledger.take_payload_beat(in_bus.cmd, in_bus.device_id, in_bus.start_address,
                                         in_bus.bytes_per_device, in_bus.payload_count,
                                         in_bus.data_byte);
            end
            if (out_bus.valid && out_bus.ready) begin
                ledger.check_framed_byte(out_bus.out_byte, out_bus.end_of_packet);
            end
        end
    end

    // The receiver stalls in short bursts while gaps are enabled.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_bus.ready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_bus.ready = 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_bus.ready = 1'b1;
            end
        end
    end

    function automatic int unsigned payload_len(logic [7:0] count);
        if (count == 0) begin
            return 1;
        end
        return (count > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : count;
    endfunction

    task automatic drive_beat(logic is_sync, logic [7:0] id, logic [15:0] addr,
                              logic [15:0] dlen, logic [7:0] count, logic [7:0] data);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_bus.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_bus.cmd              = is_sync;
        in_bus.device_id        = id;
        in_bus.start_address    = addr;
        in_bus.bytes_per_device = dlen;
        in_bus.payload_count    = count;
        in_bus.data_byte        = data;
        in_bus.valid            = 1'b1;
        forever begin
            @(posedge clk);
            if (in_bus.ready) break;
        end
    endtask

    // Beats after the first carry random header fields, which the block must ignore.
    task automatic send_packet(logic is_sync, logic [7:0] id, logic [15:0] addr,
                               logic [15:0] dlen, logic [7:0] count, logic [7:0] first_data);
        int unsigned n;
        n = payload_len(count);
        drive_beat(is_sync, id, addr, dlen, count, first_data);
        for (int i = 1; i < n; i++) begin
            drive_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned small_beats;
        int unsigned pick;
        logic [7:0]  count;
        bit          big_done;
        bit          calm_tail;
        small_beats = 0;
        big_done    = 1'b0;
        calm_tail   = 1'b0;
        in_bus.valid            = 1'b0;
        in_bus.cmd              = 1'b0;
        in_bus.device_id        = '0;
        in_bus.start_address    = '0;
        in_bus.bytes_per_device = '0;
        in_bus.payload_count    = '0;
        in_bus.data_byte        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_packet(1'b0, 8'h00, 16'h0000, 16'h0000, 8'd1, 8'h00);
        send_packet(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd1, 8'hFF);
        send_packet(1'b0, 8'hFF, 16'hFFFF, 16'h0000, 8'd0, 8'h5A);
        gaps_on = 1'b1;
        send_packet(1'b1, 8'h00, 16'h0000, 16'h0000, 8'd3, 8'hA5);
        send_packet(1'b0, 8'h01, 16'h8000, 16'hFFFF, 8'd4, 8'h80);
        send_packet(1'b1, 8'h7F, 16'h1234, 16'h5678, 8'd5, 8'h01);
        send_packet(1'b0, 8'hFE, 16'h00FF, 16'hFF00, 8'd2, 8'h7F);

        while (small_beats < 30) begin
            if (small_beats >= 20) begin
                calm_tail = 1'b1;
            end
            gaps_on = !calm_tail && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                count = 8'd0;
            end else if (pick == 1) begin
                count = 8'($urandom_range(9, 40));
            end else begin
                count = 8'($urandom_range(1, 8));
            end
            send_packet(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        count, 8'($urandom_range(0, 255)));
            small_beats += payload_len(count);
            if (!big_done && small_beats >= 10) begin
                big_done = 1'b1;
                send_packet(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)),
                            8'($urandom_range(0, 255)));
            end
        end

        @(negedge clk);
        in_bus.valid = 1'b0;
        gaps_on = 1'b0;
        while (ledger.frame_bytes_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (ledger.mismatch_count == 0 && ledger.frame_bytes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
